### hdl/lrsfd_pkg.sv
// lrsfd_pkg: shared types and constants for the led ring serial frame driver
// command encoding, phase type and sizing used by front, queue and back
// depends on nothing
`default_nettype none

package lrsfd_pkg;

	// ring size and frame layout
	localparam int NUM_LEDS    = 24;
	localparam int HALF_LEDS   = NUM_LEDS / 2;
	localparam int FRAME_WORDS = NUM_LEDS + 2;
	localparam int LED_IDX_W   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int WORD_W      = $clog2(FRAME_WORDS + 1);

	// fixed field widths
	localparam int MODE_W   = 2;
	localparam int INDEX_W  = 5;
	localparam int LEVEL_W  = 8;
	localparam int SHIFT_W  = 16;
	localparam int BIT_W    = 4;
	localparam int PULSE_W  = 2;
	localparam int LATCH_W  = 10;

	localparam logic [BIT_W-1:0]   LAST_BIT       = 4'd15;
	localparam logic [PULSE_W-1:0] LAST_PULSE     = 2'd3;
	localparam logic [LATCH_W-1:0] LATCH_WAIT_RST = 10'd220;

	// request modes
	localparam logic [MODE_W-1:0] MODE_SET  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SHOW = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

	// queue sizing
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		OP_NOP,
		OP_SET,
		OP_SHOW,
		OP_TICK
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SEND,
		PH_WAIT,
		PH_LATCH
	} phase_t;

	typedef struct packed {
		op_t                  op;
		logic [LED_IDX_W-1:0] led_addr;
		logic [LEVEL_W-1:0]   level;
	} cmd_t;

endpackage

`default_nettype wire

### hdl/lrsfd_front.sv
// lrsfd_front: accepts requests and classifies them into commands
// out-of-range sets and unused modes become no-ops; depends on lrsfd_pkg
`default_nettype none

module lrsfd_front import lrsfd_pkg::*; (
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [MODE_W-1:0]  mode,
	input  wire logic [INDEX_W-1:0] led_index,
	input  wire logic [LEVEL_W-1:0] level,
	output logic                    cmd_push,
	output cmd_t                    cmd,
	input  wire logic               q_full
);

	// request accepted whenever the queue has room
	assign in_ready = !q_full;
	assign cmd_push = in_valid && !q_full;

	// classify request
	always_comb begin
		cmd.led_addr = led_index[LED_IDX_W-1:0];
		cmd.level    = level;
		case (mode)
			MODE_SET: begin
				if ({1'b0, led_index} < (INDEX_W+1)'(NUM_LEDS)) begin
					cmd.op = OP_SET;
				end else begin
					cmd.op = OP_NOP;
				end
			end
			MODE_SHOW: cmd.op = OP_SHOW;
			MODE_TICK: cmd.op = OP_TICK;
			default:   cmd.op = OP_NOP;
		endcase
	end

endmodule

`default_nettype wire

### hdl/lrsfd_queue.sv
// lrsfd_queue: short command queue between front and back
// two entries, push and pop in the same cycle allowed; depends on lrsfd_pkg
`default_nettype none

module lrsfd_queue import lrsfd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	output logic      head_valid,
	output cmd_t      head_cmd,
	input  wire logic pop
);

	cmd_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
			end
			case ({push, pop})
				2'b10:   count_q <= QCNT_W'(count_q + 1'b1);
				2'b01:   count_q <= QCNT_W'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

### hdl/lrsfd_back.sv
// lrsfd_back: frame engine, level store and registered result stage
// one command per cycle, unless the result stalls, updates the pin state machine; depends on lrsfd_pkg
`default_nettype none

module lrsfd_back import lrsfd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [LATCH_W-1:0] cfg_wdata,
	input  wire logic               cmd_valid,
	input  wire cmd_t               cmd,
	output logic                    cmd_pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    data_pin,
	output logic                    clock_pin,
	output logic                    busy_res,
	output logic                    frame_done
);

	logic [LATCH_W-1:0] latch_wait_q;
	logic [LEVEL_W-1:0] levels_q [NUM_LEDS];

	phase_t             phase_q, phase_nxt;
	logic [WORD_W-1:0]  word_count_q, word_nxt;
	logic [BIT_W-1:0]   bit_count_q, bit_nxt;
	logic               half_step_q, half_nxt;
	logic [SHIFT_W-1:0] shift_word_q, shift_nxt;
	logic [LATCH_W-1:0] wait_count_q, wait_nxt;
	logic [PULSE_W-1:0] pulse_count_q, pulse_nxt;
	logic               data_level_q, data_nxt;
	logic               clock_level_q, clock_nxt;
	logic               done_nxt;

	logic               out_valid_q;
	logic               data_pin_q, clock_pin_q, busy_res_q, frame_done_q;
	logic               busy_nxt;

	logic               exec;
	logic               tick;
	logic [WORD_W-1:0]  fetch_w;
	logic [WORD_W-1:0]  fetch_sel;
	logic [SHIFT_W-1:0] fetch_word;
	logic               last_bit, last_word, wait_end, latch_end;
	logic [LATCH_W-1:0] wait_dec;

	// command runs when the result register is free or being taken
	assign exec    = cmd_valid && (!out_valid_q || out_ready);
	assign cmd_pop = exec;
	assign tick    = (cmd.op == OP_TICK);

	// next word of the frame, read from the level store
	always_comb begin
		fetch_w    = WORD_W'(word_count_q + 1'b1);
		fetch_word = '0;
		if (fetch_w <= WORD_W'(HALF_LEDS)) begin
			fetch_sel = WORD_W'(fetch_w - 1'b1);
		end else begin
			fetch_sel = WORD_W'(fetch_w - 2'd2);
		end
		if (fetch_w != '0 && fetch_w != WORD_W'(HALF_LEDS + 1) &&
				fetch_sel < WORD_W'(NUM_LEDS)) begin
			fetch_word = {{(SHIFT_W-LEVEL_W){1'b0}}, levels_q[fetch_sel[LED_IDX_W-1:0]]};
		end
	end

	// sequence end flags
	assign last_bit  = half_step_q && (bit_count_q == LAST_BIT);
	assign last_word = (fetch_w >= WORD_W'(FRAME_WORDS));
	assign wait_dec  = LATCH_W'(wait_count_q - 1'b1);
	assign wait_end  = (wait_dec == '0);
	assign latch_end = half_step_q && (pulse_count_q == LAST_PULSE);

	// phase next state
	always_comb begin
		phase_nxt = phase_q;
		case (phase_q)
			PH_IDLE: begin
				if (cmd.op == OP_SHOW) begin
					phase_nxt = PH_SEND;
				end
			end
			PH_SEND: begin
				if (tick && last_bit && last_word) begin
					phase_nxt = (latch_wait_q == '0) ? PH_LATCH : PH_WAIT;
				end
			end
			PH_WAIT: begin
				if (tick && wait_end) begin
					phase_nxt = PH_LATCH;
				end
			end
			PH_LATCH: begin
				if (tick && latch_end) begin
					phase_nxt = PH_IDLE;
				end
			end
			default: phase_nxt = PH_IDLE;
		endcase
	end

	// counters, shift word and pin levels
	always_comb begin
		word_nxt  = word_count_q;
		bit_nxt   = bit_count_q;
		half_nxt  = half_step_q;
		shift_nxt = shift_word_q;
		wait_nxt  = wait_count_q;
		pulse_nxt = pulse_count_q;
		data_nxt  = data_level_q;
		clock_nxt = clock_level_q;
		done_nxt  = 1'b0;
		if (cmd.op == OP_SHOW && phase_q == PH_IDLE) begin
			word_nxt  = '0;
			bit_nxt   = '0;
			half_nxt  = 1'b0;
			shift_nxt = '0;
		end else if (tick) begin
			case (phase_q)
				PH_SEND: begin
					if (!half_step_q) begin
						data_nxt = shift_word_q[SHIFT_W-1];
						half_nxt = 1'b1;
					end else begin
						clock_nxt = !clock_level_q;
						shift_nxt = {shift_word_q[SHIFT_W-2:0], 1'b0};
						half_nxt  = 1'b0;
						if (last_bit) begin
							bit_nxt = '0;
							if (last_word) begin
								word_nxt  = '0;
								pulse_nxt = '0;
								wait_nxt  = (latch_wait_q == '0) ? wait_count_q : latch_wait_q;
							end else begin
								word_nxt  = fetch_w;
								shift_nxt = fetch_word;
							end
						end else begin
							bit_nxt = BIT_W'(bit_count_q + 1'b1);
						end
					end
				end
				PH_WAIT: begin
					wait_nxt = wait_dec;
					if (wait_end) begin
						half_nxt  = 1'b0;
						pulse_nxt = '0;
					end
				end
				PH_LATCH: begin
					if (!half_step_q) begin
						data_nxt = 1'b1;
						half_nxt = 1'b1;
					end else begin
						data_nxt  = 1'b0;
						half_nxt  = 1'b0;
						pulse_nxt = PULSE_W'(pulse_count_q + 1'b1);
						if (latch_end) begin
							pulse_nxt = '0;
							done_nxt  = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// result fields
	always_comb begin
		busy_nxt = (phase_nxt != PH_IDLE);
	end

	// latch wait register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_wait_q <= LATCH_WAIT_RST;
		end else if (cfg_we) begin
			latch_wait_q <= cfg_wdata;
		end
	end

	// level store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEDS; i++) begin
				levels_q[i] <= '0;
			end
		end else if (exec && cmd.op == OP_SET) begin
			levels_q[cmd.led_addr] <= cmd.level;
		end
	end

	// engine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			word_count_q  <= '0;
			bit_count_q   <= '0;
			half_step_q   <= 1'b0;
			shift_word_q  <= '0;
			wait_count_q  <= '0;
			pulse_count_q <= '0;
			data_level_q  <= 1'b0;
			clock_level_q <= 1'b0;
		end else if (exec) begin
			phase_q       <= phase_nxt;
			word_count_q  <= word_nxt;
			bit_count_q   <= bit_nxt;
			half_step_q   <= half_nxt;
			shift_word_q  <= shift_nxt;
			wait_count_q  <= wait_nxt;
			pulse_count_q <= pulse_nxt;
			data_level_q  <= data_nxt;
			clock_level_q <= clock_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			data_pin_q   <= data_nxt;
			clock_pin_q  <= clock_nxt;
			busy_res_q   <= busy_nxt;
			frame_done_q <= done_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign data_pin   = data_pin_q;
	assign clock_pin  = clock_pin_q;
	assign busy_res   = busy_res_q;
	assign frame_done = frame_done_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && frame_done_q) |-> !busy_res_q)
		else $error("frame done reported while busy");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (word_count_q == '0 && bit_count_q == '0 && !half_step_q))
		else $error("counters not cleared in idle");

	a_send_word_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SEND) |-> (word_count_q < WORD_W'(FRAME_WORDS)))
		else $error("word count past frame end");

	a_clock_in_send: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && clock_nxt != clock_level_q) |-> (phase_q == PH_SEND && tick))
		else $error("clock line toggled outside a send tick");

endmodule

`default_nettype wire

### hdl/led_ring_serial_frame_driver.sv
// led_ring_serial_frame_driver: top level of the two-wire led ring frame driver
// front classifier, command queue and frame engine; depends on lrsfd_pkg
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  request  | in_valid, in_ready, mode, led_index, level | in
//  result   | out_valid, out_ready, data_pin, clock_pin, | out
//           | busy_res, frame_done                     |
//  config   | cfg_we, cfg_wdata (latch_wait)           | in
//
// one request per cycle while the result is taken; an accepted request is
// written into the queue and waits at the queue head, then the frame engine
// update and its result stage are registered together at one edge
// reset (arst_n low) clears all levels, the engine and the queue; latch_wait
// returns to 220
// a stalled result stalls the engine; the two-entry queue keeps in_ready high
// until it fills, so up to two requests can wait out a stalled result
`default_nettype none

module led_ring_serial_frame_driver import lrsfd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [LATCH_W-1:0] cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [MODE_W-1:0]  mode,
	input  wire logic [INDEX_W-1:0] led_index,
	input  wire logic [LEVEL_W-1:0] level,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    data_pin,
	output logic                    clock_pin,
	output logic                    busy_res,
	output logic                    frame_done
);

	logic cmd_push;
	cmd_t push_cmd;
	logic q_full;
	logic head_valid;
	cmd_t head_cmd;
	logic cmd_pop;

	// classify requests
	lrsfd_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.led_index (led_index),
		.level     (level),
		.cmd_push  (cmd_push),
		.cmd       (push_cmd),
		.q_full    (q_full)
	);

	// decoupling queue
	lrsfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (cmd_pop)
	);

	// frame engine
	lrsfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.cmd_valid  (head_valid),
		.cmd        (head_cmd),
		.cmd_pop    (cmd_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.data_pin   (data_pin),
		.clock_pin  (clock_pin),
		.busy_res   (busy_res),
		.frame_done (frame_done)
	);

endmodule

`default_nettype wire
